@@ rtl/core/mhd_wave_speeds_top_macros.svh @@
// Assertion macros of the wave speed pipeline top level.
`ifndef MHD_WAVE_SPEEDS_TOP_MACROS_SVH
`define MHD_WAVE_SPEEDS_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define MHD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset.
`define MHD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MHD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define MHD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/core/mhd_pkg.sv @@
// Shared types and constants of the MHD wave speed pipeline.
`default_nettype none
package mhd_pkg;

    localparam int DENS_W      = 31;
    localparam int PRES_W      = 31;
    localparam int COMP_W      = 32;
    localparam int NUM_SPEEDS  = 8;
    localparam int STATUS_W    = 2;
    localparam int VN_W        = 50;   // normal velocity before saturation
    localparam int SUM_W       = VN_W + 1;
    localparam int WIDE_W      = 64;
    localparam int DISC_W      = 2 * WIDE_W;
    localparam int FRAC_W      = 16;
    localparam int QUO_W       = WIDE_W + FRAC_W;
    localparam int ROOT2_W     = QUO_W / 2;
    localparam int NUM_LANES   = 3;
    localparam int IN_TDATA_W  = 352;
    localparam int OUT_TDATA_W = NUM_SPEEDS * COMP_W;

    // floor(x/3) = (x * RECIP3) >> 33 for any 32-bit x
    localparam logic [31:0] RECIP3       = 32'hAAAA_AAAB;
    localparam int          RECIP3_SHIFT = 33;

    // lanes of the divide and root units
    localparam int LANE_FAST = 0;
    localparam int LANE_ALF  = 1;
    localparam int LANE_SLOW = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_DENS = 2'd1,
        ST_SAT  = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]          pad;
        logic signed [31:0]  normal_z;
        logic signed [31:0]  normal_y;
        logic signed [31:0]  normal_x;
        logic signed [31:0]  field_z;
        logic signed [31:0]  field_y;
        logic signed [31:0]  field_x;
        logic signed [31:0]  velocity_z;
        logic signed [31:0]  velocity_y;
        logic signed [31:0]  velocity_x;
        logic [PRES_W-1:0]   pressure;
        logic [DENS_W-1:0]   density;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] fast_plus;
        logic signed [31:0] alfven_plus;
        logic signed [31:0] slow_plus;
        logic signed [31:0] entropy_b;
        logic signed [31:0] entropy_a;
        logic signed [31:0] slow_minus;
        logic signed [31:0] alfven_minus;
        logic signed [31:0] fast_minus;
    } t_out_word;

    // carried alongside the discriminant root
    typedef struct packed {
        logic                   zero;
        logic [DENS_W-1:0]      dens;
        logic signed [VN_W-1:0] vn;
        logic [WIDE_W-1:0]      c;
        logic [WIDE_W-1:0]      s;
    } t_side1;

    // carried alongside the divide and the speed roots
    typedef struct packed {
        logic                   zero;
        logic signed [VN_W-1:0] vn;
    } t_side2;

endpackage
`default_nettype wire

@@ rtl/core/mhd_wave_speeds_top.sv @@
// Top level of the ideal MHD characteristic wave speed pipeline.
// Usage:
//  - Slave stream (i_s_*) takes one cell state per word: density, pressure,
//    velocity, magnetic field and a unit direction, all Q16.16.
//  - Master stream (o_m_*) returns one word per cell: the eight speeds along
//    the direction (fast-, Alfven-, slow-, entropy, entropy, slow+, Alfven+,
//    fast+) in tdata and a status code in tuser (ok, density not positive,
//    saturated).
//  - A word passes 194 register stages: six front stages, 65 for the
//    64-bit discriminant root, 81 for the 80-bit divide by density, 41 for
//    the speed roots and one output register.
//  - Throughput is one word per cycle while the skid register is empty; the
//    bit-per-stage root and divide pipelines set the depth, not the rate.
//  - Reset clears every valid bit, including the output and skid flags; no
//    clearing pass is needed, the block is ready on the next cycle.
//  - When the receiver stalls, a finished word parks in a skid register and
//    the input keeps flowing for that cycle; with the skid full the whole
//    pipeline freezes in place and o_s_tready drops, nothing is lost.
`default_nettype none
`include "mhd_wave_speeds_top_macros.svh"
module mhd_wave_speeds_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // density, pressure, velocity_x/y/z, field_x/y/z, normal_x/y/z, 2 pad bits
    input  logic [mhd_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    // master stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // fast_minus, alfven_minus, slow_minus, entropy_a, entropy_b,
    // slow_plus, alfven_plus, fast_plus
    output logic [mhd_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    // status
    output logic [mhd_pkg::STATUS_W-1:0]        o_m_tuser
);
    localparam int SUM_W = mhd_pkg::SUM_W;
    localparam int VN_W  = mhd_pkg::VN_W;
    localparam int R2_W  = mhd_pkg::ROOT2_W;

    // pipeline advance: frozen only while the skid register holds a word
    logic en;

    mhd_pkg::t_in_word in_word;

    logic                            f_valid;
    logic [mhd_pkg::DISC_W-1:0]      f_disc;
    mhd_pkg::t_side1                 f_side;

    logic                                    r1_valid;
    logic [0:0][mhd_pkg::WIDE_W-1:0]         r1_root;
    mhd_pkg::t_side1                         r1_side;

    logic [mhd_pkg::WIDE_W:0]                sum_sr;
    logic [mhd_pkg::WIDE_W-1:0]              wf, ws;
    logic [mhd_pkg::NUM_LANES-1:0][mhd_pkg::QUO_W-1:0] div_num;
    mhd_pkg::t_side2                         div_side;

    logic                                    d_valid;
    logic [mhd_pkg::NUM_LANES-1:0][mhd_pkg::QUO_W-1:0] d_quo;
    mhd_pkg::t_side2                         d_side;

    logic                                    p_valid;
    logic [mhd_pkg::NUM_LANES-1:0][R2_W-1:0] p_root;
    mhd_pkg::t_side2                         p_side;

    logic signed [SUM_W-1:0]  vn_ext;
    logic signed [SUM_W-1:0]  spd [mhd_pkg::NUM_LANES];
    logic signed [SUM_W-1:0]  sp  [mhd_pkg::NUM_SPEEDS];
    logic [31:0]              sp_sat [mhd_pkg::NUM_SPEEDS];
    logic [mhd_pkg::NUM_SPEEDS-1:0] sat_hit;
    mhd_pkg::t_out_word       res_data;
    mhd_pkg::t_status         res_status;

    // output register and skid stage
    logic                     r_out_v;
    mhd_pkg::t_out_word       r_out_data;
    mhd_pkg::t_status         r_out_status;
    logic                     r_skid_v;
    mhd_pkg::t_out_word       r_skid_data;
    mhd_pkg::t_status         r_skid_status;
    logic                     out_free;

    assign in_word    = mhd_pkg::t_in_word'(i_s_tdata);
    assign en         = !r_skid_v;
    assign o_s_tready = en;

    // products, sums and the clamped discriminant S^2 - 4AC
    mhd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_tvalid),
        .i_word  (in_word),
        .o_valid (f_valid),
        .o_disc  (f_disc),
        .o_side  (f_side)
    );

    // R = floor(sqrt(D))
    mhd_sqrt_pipe #(
        .W      (mhd_pkg::DISC_W),
        .LANES  (1),
        .SIDE_W ($bits(mhd_pkg::t_side1))
    ) u_sqrt_disc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_x     (f_disc),
        .i_side  (f_side),
        .o_valid (r1_valid),
        .o_root  (r1_root),
        .o_side  (r1_side)
    );

    // fast and slow rho*c^2; R never exceeds S
    assign sum_sr = {1'b0, r1_side.s} + {1'b0, r1_root[0]};
    assign wf     = sum_sr[mhd_pkg::WIDE_W:1];
    assign ws     = (r1_side.s - r1_root[0]) >> 1;

    assign div_num[mhd_pkg::LANE_FAST] = {wf, {mhd_pkg::FRAC_W{1'b0}}};
    assign div_num[mhd_pkg::LANE_ALF]  = {r1_side.c, {mhd_pkg::FRAC_W{1'b0}}};
    assign div_num[mhd_pkg::LANE_SLOW] = {ws, {mhd_pkg::FRAC_W{1'b0}}};
    assign div_side.zero = r1_side.zero;
    assign div_side.vn   = r1_side.vn;

    // floor(W * 2^16 / rho) for all three waves
    mhd_div_pipe #(
        .QW     (mhd_pkg::QUO_W),
        .DW     (mhd_pkg::DENS_W),
        .LANES  (mhd_pkg::NUM_LANES),
        .SIDE_W ($bits(mhd_pkg::t_side2))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r1_valid),
        .i_num   (div_num),
        .i_den   (r1_side.dens),
        .i_side  (div_side),
        .o_valid (d_valid),
        .o_quo   (d_quo),
        .o_side  (d_side)
    );

    // speeds in Q16.16
    mhd_sqrt_pipe #(
        .W      (mhd_pkg::QUO_W),
        .LANES  (mhd_pkg::NUM_LANES),
        .SIDE_W ($bits(mhd_pkg::t_side2))
    ) u_sqrt_speed (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (d_valid),
        .i_x     (d_quo),
        .i_side  (d_side),
        .o_valid (p_valid),
        .o_root  (p_root),
        .o_side  (p_side)
    );

    // add, saturate and pick the status
    always_comb begin
        vn_ext = {p_side.vn[VN_W-1], p_side.vn};
        for (int l = 0; l < mhd_pkg::NUM_LANES; l++) begin
            spd[l] = $signed({{(SUM_W - R2_W){1'b0}}, p_root[l]});
        end
        sp[0] = vn_ext - spd[mhd_pkg::LANE_FAST];
        sp[1] = vn_ext - spd[mhd_pkg::LANE_ALF];
        sp[2] = vn_ext - spd[mhd_pkg::LANE_SLOW];
        sp[3] = vn_ext;
        sp[4] = vn_ext;
        sp[5] = vn_ext + spd[mhd_pkg::LANE_SLOW];
        sp[6] = vn_ext + spd[mhd_pkg::LANE_ALF];
        sp[7] = vn_ext + spd[mhd_pkg::LANE_FAST];
        for (int i = 0; i < mhd_pkg::NUM_SPEEDS; i++) begin
            // in range when every bit above bit 31 copies the sign
            sat_hit[i] = !((sp[i][SUM_W-1:31] == '0) || (sp[i][SUM_W-1:31] == '1));
            if (!sat_hit[i]) begin
                sp_sat[i] = sp[i][31:0];
            end else if (sp[i][SUM_W-1]) begin
                sp_sat[i] = 32'h8000_0000;
            end else begin
                sp_sat[i] = 32'h7FFF_FFFF;
            end
        end
        if (p_side.zero) begin
            res_data   = '0;
            res_status = mhd_pkg::ST_DENS;
        end else begin
            res_data.fast_minus   = sp_sat[0];
            res_data.alfven_minus = sp_sat[1];
            res_data.slow_minus   = sp_sat[2];
            res_data.entropy_a    = sp_sat[3];
            res_data.entropy_b    = sp_sat[4];
            res_data.slow_plus    = sp_sat[5];
            res_data.alfven_plus  = sp_sat[6];
            res_data.fast_plus    = sp_sat[7];
            res_status = (sat_hit != '0) ? mhd_pkg::ST_SAT : mhd_pkg::ST_OK;
        end
    end

    assign out_free = !r_out_v || i_m_tready;

    // drain the skid first; park a new word there only when the output is held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (out_free) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (p_valid) begin
            if (out_free) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (out_free) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (out_free) begin
                r_out_data   <= r_skid_data;
                r_out_status <= r_skid_status;
            end
        end else if (p_valid) begin
            if (out_free) begin
                r_out_data   <= res_data;
                r_out_status <= res_status;
            end else begin
                r_skid_data   <= res_data;
                r_skid_status <= res_status;
            end
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_status;

    `MHD_ASSERT_IMP(a_skid_needs_out, i_clk, i_rst_n, r_skid_v, r_out_v, "skid full with output empty")
    `MHD_ASSERT_NXT(a_skid_holds, i_clk, i_rst_n, (r_skid_v && !i_m_tready), r_skid_v, "skid word dropped while stalled")
    `MHD_ASSERT_NXT(a_pipe_frozen, i_clk, i_rst_n, (r_skid_v && p_valid), p_valid, "pipeline word lost while frozen")
    `MHD_ASSERT_IMP(a_dens_zero, i_clk, i_rst_n, (r_out_v && (r_out_status == mhd_pkg::ST_DENS)), (r_out_data == '0), "nonzero speeds for zero density")

endmodule
`default_nettype wire

@@ rtl/core/mhd_front.sv @@
// Front pipeline: dot products, magnitudes and the clamped discriminant.
`default_nettype none
module mhd_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  mhd_pkg::t_in_word              i_word,
    output logic                           o_valid,
    output logic [mhd_pkg::DISC_W-1:0]     o_disc,
    output mhd_pkg::t_side1                o_side
);
    localparam int VN_W = mhd_pkg::VN_W;
    localparam logic signed [VN_W-1:0] BN_MAX = VN_W'(64'sd2147483647);
    localparam logic signed [VN_W-1:0] BN_MIN = VN_W'(-64'sd2147483648);

    logic signed [31:0] vel [3];
    logic signed [31:0] fld [3];
    logic signed [31:0] nrm [3];
    logic [31:0]        bmag [3];

    // stage 1: products
    logic               r1_v;
    logic signed [63:0] r1_pv [3];
    logic signed [63:0] r1_pb [3];
    logic [63:0]        r1_bsq [3];
    logic [63:0]        r1_ap;
    logic [30:0]        r1_p;
    logic [30:0]        r1_d;
    logic               r1_zero;
    logic signed [63:0] n_pv [3];
    logic signed [63:0] n_pb [3];
    logic [63:0]        n_bsq [3];

    // stage 2: sums
    logic                   r2_v;
    logic signed [VN_W-1:0] r2_vn;
    logic signed [31:0]     r2_bn;
    logic [63:0]            r2_bb;
    logic [31:0]            r2_a;
    logic [30:0]            r2_d;
    logic                   r2_zero;
    logic signed [VN_W-1:0] n_vn;
    logic signed [VN_W-1:0] bsum;
    logic signed [31:0]     n_bn;

    // stage 3: Bn squared and S
    logic                   r3_v;
    logic [63:0]            r3_c;
    logic [63:0]            r3_s;
    logic [31:0]            r3_a;
    logic signed [VN_W-1:0] r3_vn;
    logic [30:0]            r3_d;
    logic                   r3_zero;
    logic [31:0]            bnmag;

    // stage 4: partial products of S*S and A*C
    logic                   r4_v;
    logic [63:0]            r4_ss_ll, r4_ss_lh, r4_ss_hh;
    logic [63:0]            r4_ac_ll, r4_ac_lh;
    logic [47:0]            r4_ac_hl, r4_ac_hh;
    logic [63:0]            r4_c, r4_s;
    logic signed [VN_W-1:0] r4_vn;
    logic [30:0]            r4_d;
    logic                   r4_zero;
    logic [31:0]            al;
    logic [15:0]            ah;

    // stage 5: S^2 and 4AC
    logic                   r5_v;
    logic [127:0]           r5_s2, r5_m4;
    logic [63:0]            r5_c, r5_s;
    logic signed [VN_W-1:0] r5_vn;
    logic [30:0]            r5_d;
    logic                   r5_zero;
    logic [111:0]           m_ac;

    // stage 6: clamped discriminant
    logic                   r6_v;
    logic [127:0]           r6_disc;
    mhd_pkg::t_side1        r6_side;

    assign vel[0] = i_word.velocity_x;
    assign vel[1] = i_word.velocity_y;
    assign vel[2] = i_word.velocity_z;
    assign fld[0] = i_word.field_x;
    assign fld[1] = i_word.field_y;
    assign fld[2] = i_word.field_z;
    assign nrm[0] = i_word.normal_x;
    assign nrm[1] = i_word.normal_y;
    assign nrm[2] = i_word.normal_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_pv[i]  = vel[i] * nrm[i];
            n_pb[i]  = fld[i] * nrm[i];
            bmag[i]  = fld[i][31] ? 32'(-fld[i]) : 32'(fld[i]);
            n_bsq[i] = 64'(bmag[i]) * 64'(bmag[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pv   <= n_pv;
            r1_pb   <= n_pb;
            r1_bsq  <= n_bsq;
            r1_ap   <= 64'({i_word.pressure, 1'b0}) * 64'(mhd_pkg::RECIP3);
            r1_p    <= i_word.pressure;
            r1_d    <= i_word.density;
            r1_zero <= (i_word.density == '0);
        end
    end

    // stage 2: floor16 of each product is an arithmetic shift
    always_comb begin
        n_vn = VN_W'(r1_pv[0] >>> 16) + VN_W'(r1_pv[1] >>> 16) + VN_W'(r1_pv[2] >>> 16);
        bsum = VN_W'(r1_pb[0] >>> 16) + VN_W'(r1_pb[1] >>> 16) + VN_W'(r1_pb[2] >>> 16);
        if (bsum > BN_MAX) begin
            n_bn = 32'sh7FFF_FFFF;
        end else if (bsum < BN_MIN) begin
            n_bn = 32'sh8000_0000;
        end else begin
            n_bn = 32'(bsum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_vn   <= n_vn;
            r2_bn   <= n_bn;
            r2_bb   <= r1_bsq[0] + r1_bsq[1] + r1_bsq[2];
            r2_a    <= 32'({1'b0, r1_p}) + 32'(r1_ap >> mhd_pkg::RECIP3_SHIFT);
            r2_d    <= r1_d;
            r2_zero <= r1_zero;
        end
    end

    // stage 3
    assign bnmag = r2_bn[31] ? 32'(-r2_bn) : 32'(r2_bn);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_c    <= 64'(bnmag) * 64'(bnmag);
            r3_s    <= 64'({r2_a, 16'b0}) + r2_bb;
            r3_a    <= r2_a;
            r3_vn   <= r2_vn;
            r3_d    <= r2_d;
            r3_zero <= r2_zero;
        end
    end

    // stage 4: A = {a, 16 zeros} splits into a 32-bit low and 16-bit high part
    assign al = {r3_a[15:0], 16'b0};
    assign ah = r3_a[31:16];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_ss_ll <= 64'(r3_s[31:0]) * 64'(r3_s[31:0]);
            r4_ss_lh <= 64'(r3_s[31:0]) * 64'(r3_s[63:32]);
            r4_ss_hh <= 64'(r3_s[63:32]) * 64'(r3_s[63:32]);
            r4_ac_ll <= 64'(al) * 64'(r3_c[31:0]);
            r4_ac_lh <= 64'(al) * 64'(r3_c[63:32]);
            r4_ac_hl <= 48'(ah) * 48'(r3_c[31:0]);
            r4_ac_hh <= 48'(ah) * 48'(r3_c[63:32]);
            r4_c     <= r3_c;
            r4_s     <= r3_s;
            r4_vn    <= r3_vn;
            r4_d     <= r3_d;
            r4_zero  <= r3_zero;
        end
    end

    // stage 5
    assign m_ac = {r4_ac_hh, 64'b0} + 112'({r4_ac_lh, 32'b0})
                + 112'({r4_ac_hl, 32'b0}) + 112'(r4_ac_ll);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_s2   <= {r4_ss_hh, 64'b0} + 128'({r4_ss_lh, 33'b0}) + 128'(r4_ss_ll);
            r5_m4   <= 128'({m_ac, 2'b0});
            r5_c    <= r4_c;
            r5_s    <= r4_s;
            r5_vn   <= r4_vn;
            r5_d    <= r4_d;
            r5_zero <= r4_zero;
        end
    end

    // stage 6: clamp the discriminant at zero
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_disc      <= (r5_m4 <= r5_s2) ? (r5_s2 - r5_m4) : '0;
            r6_side.zero <= r5_zero;
            r6_side.dens <= r5_d;
            r6_side.vn   <= r5_vn;
            r6_side.c    <= r5_c;
            r6_side.s    <= r5_s;
        end
    end

    assign o_valid = r6_v;
    assign o_disc  = r6_disc;
    assign o_side  = r6_side;

endmodule
`default_nettype wire

@@ rtl/core/mhd_sqrt_pipe.sv @@
// Pipelined integer square root, one result bit per stage, several lanes.
`default_nettype none
module mhd_sqrt_pipe #(
    parameter int W      = mhd_pkg::DISC_W,
    parameter int LANES  = 1,
    parameter int SIDE_W = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [LANES-1:0][W-1:0]     i_x,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_valid,
    output logic [LANES-1:0][W/2-1:0]   o_root,
    output logic [SIDE_W-1:0]           o_side
);
    localparam int RW   = W / 2;
    localparam int REMW = RW + 2;

    logic [RW:0]                  r_v;
    logic [LANES-1:0][W-1:0]      r_x    [RW];
    logic [LANES-1:0][REMW-1:0]   r_rem  [RW];
    logic [LANES-1:0][RW-1:0]     r_root [RW+1];
    logic [SIDE_W-1:0]            r_side [RW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[RW-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= i_x;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 1; k <= RW; k++) begin : g_step
        logic [LANES-1:0][REMW-1:0] rem_sh;
        logic [LANES-1:0][REMW-1:0] trial;
        logic [LANES-1:0]           ge;
        logic [LANES-1:0][RW-1:0]   n_root;

        // bring down two bits, try root*4+1
        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                rem_sh[l] = {r_rem[k-1][l][REMW-3:0], r_x[k-1][l][W-1 -: 2]};
                trial[l]  = {r_root[k-1][l], 2'b01};
                ge[l]     = (rem_sh[l] >= trial[l]);
                n_root[l] = {r_root[k-1][l][RW-2:0], ge[l]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k] <= n_root;
                r_side[k] <= r_side[k-1];
            end
        end

        if (k < RW) begin : g_carry
            logic [LANES-1:0][REMW-1:0] n_rem;

            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    n_rem[l] = ge[l] ? (rem_sh[l] - trial[l]) : rem_sh[l];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                    for (int l = 0; l < LANES; l++) begin
                        r_x[k][l] <= r_x[k-1][l] << 2;
                    end
                end
            end
        end
    end

    assign o_valid = r_v[RW];
    assign o_root  = r_root[RW];
    assign o_side  = r_side[RW];

endmodule
`default_nettype wire

@@ rtl/core/mhd_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per stage, shared divisor.
`default_nettype none
module mhd_div_pipe #(
    parameter int QW     = mhd_pkg::QUO_W,
    parameter int DW     = mhd_pkg::DENS_W,
    parameter int LANES  = mhd_pkg::NUM_LANES,
    parameter int SIDE_W = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [LANES-1:0][QW-1:0]  i_num,
    input  logic [DW-1:0]             i_den,
    input  logic [SIDE_W-1:0]         i_side,
    output logic                      o_valid,
    output logic [LANES-1:0][QW-1:0]  o_quo,
    output logic [SIDE_W-1:0]         o_side
);
    // dividend bits shift out the top of r_q while quotient bits shift in
    logic [QW:0]                  r_v;
    logic [LANES-1:0][QW-1:0]     r_q    [QW+1];
    logic [LANES-1:0][DW-1:0]     r_rem  [QW];
    logic [DW-1:0]                r_den  [QW];
    logic [SIDE_W-1:0]            r_side [QW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QW-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0]    <= i_num;
            r_rem[0]  <= '0;
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [LANES-1:0][DW:0]   rem_sh;
        logic [LANES-1:0]         ge;
        logic [LANES-1:0][QW-1:0] n_q;

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                rem_sh[l] = {r_rem[k-1][l], r_q[k-1][l][QW-1]};
                ge[l]     = (rem_sh[l] >= {1'b0, r_den[k-1]});
                n_q[l]    = {r_q[k-1][l][QW-2:0], ge[l]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k]    <= n_q;
                r_side[k] <= r_side[k-1];
            end
        end

        if (k < QW) begin : g_carry
            logic [LANES-1:0][DW-1:0] n_rem;

            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    n_rem[l] = ge[l] ? DW'(rem_sh[l] - {1'b0, r_den[k-1]})
                                     : rem_sh[l][DW-1:0];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                    r_den[k] <= r_den[k-1];
                end
            end
        end
    end

    assign o_valid = r_v[QW];
    assign o_quo   = r_q[QW];
    assign o_side  = r_side[QW];

endmodule
`default_nettype wire
